// File: rtl/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

	localparam int KEY_W      = 32;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int ENTRIES_W  = 7;
	localparam int CAPACITY   = 64;

	typedef logic signed [KEY_W-1:0]  key_t;
	typedef logic [OP_W-1:0]          op_t;
	typedef logic [STATUS_W-1:0]      status_t;
	typedef logic [ENTRIES_W-1:0]     entries_t;

	localparam op_t OP_INSERT     = 2'd0;
	localparam op_t OP_REMOVE_MAX = 2'd1;
	localparam op_t OP_REMOVE_MIN = 2'd2;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	// broadcast command to every cell, already qualified by full/empty
	typedef struct packed {
		logic ins;
		logic rmax;
		logic rmin;
	} cell_ctrl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic valid;
		key_t key;
		logic gt;     // new key belongs in front of this cell
	} cell_link_t;

endpackage

`default_nettype wire

// File: rtl/mhpq_req_if.sv
`default_nettype none

interface mhpq_req_if;
	logic              valid;
	logic              ready;
	mhpq_pkg::op_t     op;
	mhpq_pkg::key_t    key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

`default_nettype wire

// File: rtl/mhpq_rsp_if.sv
`default_nettype none

interface mhpq_rsp_if;
	logic                 valid;
	logic                 ready;
	mhpq_pkg::key_t       value;
	mhpq_pkg::status_t    status;
	mhpq_pkg::entries_t   entries;

	modport source (output valid, output value, output status, output entries, input ready);
	modport sink   (input valid, input value, input status, input entries, output ready);
endinterface

`default_nettype wire

// File: rtl/mhpq_cell.sv
`default_nettype none

module mhpq_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire mhpq_pkg::cell_ctrl_t   ctrl,
	input  wire mhpq_pkg::key_t         new_key,
	input  wire mhpq_pkg::cell_link_t   left,
	input  wire mhpq_pkg::cell_link_t   right,
	output mhpq_pkg::cell_link_t        self,
	output logic                        last
);

	logic            valid_q;
	mhpq_pkg::key_t  key_q;
	logic            gt;

	// ties go behind existing equal keys
	assign gt   = !valid_q || (new_key > key_q);
	assign last = valid_q && !right.valid;

	assign self.valid = valid_q;
	assign self.key   = key_q;
	assign self.gt    = gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (left.gt) begin
				valid_q <= left.valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.rmax) begin
			valid_q <= right.valid;
		end else if (ctrl.rmin && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left.gt) begin
				key_q <= left.key;
			end else if (gt) begin
				key_q <= new_key;
			end
		end else if (ctrl.rmax) begin
			key_q <= right.key;
		end
	end

endmodule

`default_nettype wire

// File: rtl/max_heap_priority_queue_core.sv
`default_nettype none

// Bounded priority queue of signed 32-bit keys built as a sorted row of
// CAPACITY cells, largest key in cell 0. Each request beat is one operation
// (insert, remove largest, remove smallest) and yields exactly one response
// beat with the removed key, a status and the entry count afterwards.
// Throughput: one operation per cycle. A request is taken in the cycle it is
// offered while the response register is empty or being drained; its
// response appears the next cycle. The figure is set by the update of the
// cell row: on insert every cell compares the new key with its own in
// parallel and either keeps, takes the new key or takes its left
// neighbor's key; remove-largest shifts the row left by one; remove-smallest
// drops the last occupied cell. Insert into a full queue is dropped with
// status full, removal from an empty queue returns status empty, and an
// undefined op code returns ok with no change. Entries carries the low
// seven bits of the count. No clearing pass is needed after reset.

module max_heap_priority_queue_core #(
	parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
	input  wire          clk,
	input  wire          arst_n,
	mhpq_req_if.sink     req,
	mhpq_rsp_if.source   rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W = mhpq_pkg::ENTRIES_W;

	// occupancy
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_n;

	// response register
	logic                 rsp_valid_q;
	mhpq_pkg::key_t       value_q;
	mhpq_pkg::status_t    status_q;
	mhpq_pkg::entries_t   entries_q;

	logic                 accept;
	logic                 is_ins, is_rmax, is_rmin;
	logic                 full, empty;
	mhpq_pkg::cell_ctrl_t ctrl;

	mhpq_pkg::cell_link_t links [CAPACITY];
	logic [CAPACITY-1:0]  last;
	mhpq_pkg::key_t       min_key;
	mhpq_pkg::key_t       value_n;
	mhpq_pkg::status_t    status_n;
	logic [CNT_W+ENT_W-1:0] count_ext;

	// skid-free handoff: accept while the response slot is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_ins  = (req.op == mhpq_pkg::OP_INSERT);
	assign is_rmax = (req.op == mhpq_pkg::OP_REMOVE_MAX);
	assign is_rmin = (req.op == mhpq_pkg::OP_REMOVE_MIN);

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign ctrl.ins  = accept && is_ins  && !full;
	assign ctrl.rmax = accept && is_rmax && !empty;
	assign ctrl.rmin = accept && is_rmin && !empty;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mhpq_pkg::cell_link_t left_link;
		mhpq_pkg::cell_link_t right_link;

		if (i == 0) begin : g_head
			// nothing shifts in from the left of the head cell
			assign left_link = '{valid: 1'b1, key: '0, gt: 1'b0};
		end else begin : g_body_l
			assign left_link = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_link = '{valid: 1'b0, key: '0, gt: 1'b1};
		end else begin : g_body_r
			assign right_link = links[i+1];
		end

		mhpq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.new_key (req.key),
			.left    (left_link),
			.right   (right_link),
			.self    (links[i]),
			.last    (last[i])
		);
	end

	// smallest key sits in the one cell flagged last: and-or select
	always_comb begin
		min_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			min_key = min_key | (links[i].key & {mhpq_pkg::KEY_W{last[i]}});
		end
	end

	always_comb begin
		value_n  = '0;
		status_n = mhpq_pkg::STATUS_OK;
		count_n  = count_q;
		if (ctrl.ins) begin
			count_n = count_q + CNT_W'(1);
		end else if (ctrl.rmax) begin
			value_n = links[0].key;
			count_n = count_q - CNT_W'(1);
		end else if (ctrl.rmin) begin
			value_n = min_key;
			count_n = count_q - CNT_W'(1);
		end else if (is_ins && full) begin
			status_n = mhpq_pkg::STATUS_FULL;
		end else if ((is_rmax || is_rmin) && empty) begin
			status_n = mhpq_pkg::STATUS_EMPTY;
		end
	end

	assign count_ext = {{ENT_W{1'b0}}, count_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q   <= value_n;
			status_q  <= status_n;
			entries_q <= count_ext[ENT_W-1:0];
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.value   = value_q;
	assign rsp.status  = status_q;
	assign rsp.entries = entries_q;

endmodule

`default_nettype wire
